### hdl/fra_pkg.sv
// Shared types, constants and register map of the fragment reassembly buffer.
package fra_pkg;

	localparam int TOTAL_W            = 18;
	localparam int POS_IN_W           = 16;
	localparam int MSG_W              = 2;
	localparam int CNT_W              = 3;
	localparam int ORDER_W            = 8;
	localparam int NUM_LEN_REGS       = 4;
	localparam int QUEUE_DEPTH        = 2;
	localparam int DEF_MAX_MESSAGES   = 4;
	localparam int DEF_FRAGMENT_SLOTS = 64;
	localparam int DEF_LENGTH_BITS    = 16;
	localparam int PADDR_W            = 5;

	localparam logic [2:0] REG_MSG_COUNT = 3'd0;
	localparam logic [2:0] REG_ORDER     = 3'd1;
	localparam logic [2:0] REG_LEN0      = 3'd2;
	localparam logic [2:0] REG_LEN1      = 3'd3;
	localparam logic [2:0] REG_LEN2      = 3'd4;
	localparam logic [2:0] REG_LEN3      = 3'd5;

	localparam logic [CNT_W-1:0]   RST_MSG_COUNT = 3'd4;
	localparam logic [ORDER_W-1:0] RST_ORDER     = 8'd228;
	localparam logic [POS_IN_W-1:0] RST_LEN      = 16'd1;

	typedef enum logic [1:0] {
		K_FRAG,
		K_BAD,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [MSG_W-1:0]    msg;
		logic [POS_IN_W-1:0] first;
		logic [POS_IN_W-1:0] last;
	} item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STORE,
		S_DRAIN_CHK,
		S_SCAN,
		S_DECIDE,
		S_FINISH
	} state_t;

	typedef logic [NUM_LEN_REGS-1:0][POS_IN_W-1:0] len_arr_t;

endpackage

### hdl/fra_fifo.sv
// Short queue of classified items between front and back.
module fra_fifo import fra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### hdl/fra_front.sv
// Input side: takes items and sorts them into clear, fragment and bad message.
module fra_front import fra_pkg::*; (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [MSG_W-1:0]    message_number,
	input  logic [POS_IN_W-1:0] first_byte,
	input  logic [POS_IN_W-1:0] last_byte,
	input  logic [CNT_W-1:0]    act_count,
	input  logic                q_full,
	output logic                push,
	output item_t               push_item
);

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.msg   = message_number;
		push_item.first = first_byte;
		push_item.last  = last_byte;
		if (mode)
			push_item.kind = K_CLEAR;
		else if ({1'b0, message_number} >= act_count)
			push_item.kind = K_BAD;
		else
			push_item.kind = K_FRAG;
	end

endmodule

### hdl/fra_back.sv
// Execution side: fragment store, in-order draining, occupancy and result register.
module fra_back import fra_pkg::*; #(
	parameter int MAX_MESSAGES   = DEF_MAX_MESSAGES,
	parameter int FRAGMENT_SLOTS = DEF_FRAGMENT_SLOTS,
	parameter int LENGTH_BITS    = DEF_LENGTH_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  item_t               head,
	input  logic                q_empty,
	output logic                pop,
	input  logic [CNT_W-1:0]    act_count,
	input  logic [ORDER_W-1:0]  order,
	input  len_arr_t            lengths,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TOTAL_W-1:0]  buffered_bytes,
	output logic [TOTAL_W-1:0]  peak_bytes,
	output logic [CNT_W-1:0]    messages_done,
	output logic                dropped
);

	localparam int LB    = LENGTH_BITS;
	localparam int AW    = (FRAGMENT_SLOTS > 1) ? $clog2(FRAGMENT_SLOTS) : 1;
	localparam int MIW   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int ENT_W = MSG_W + 2 * LB;

	state_t state_q, state_d;
	item_t  cur_q;

	logic [FRAGMENT_SLOTS-1:0] valid_q;
	logic [ENT_W-1:0]          mem [FRAGMENT_SLOTS];
	logic [ENT_W-1:0]          rd_data_s1;
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_idx_s1;
	logic [AW:0]               scan_cnt_q;

	logic          best_v_q;
	logic [AW-1:0] best_idx_q;
	logic [LB-1:0] best_first_q, best_last_q;
	logic [MSG_W-1:0] cur_id_q;

	logic [LB:0]        nexp_q [MAX_MESSAGES];
	logic [CNT_W-1:0]   pos_q;
	logic [TOTAL_W-1:0] total_q, peak_q;
	logic               dropped_q;

	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q, out_peak_q;
	logic [CNT_W-1:0]   out_pos_q;
	logic               out_drop_q;

	// free slot search
	logic          free_found;
	logic [AW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < FRAGMENT_SLOTS; i++) begin
			if (!valid_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	logic [LB-1:0]      cur_first, cur_last;
	logic [TOTAL_W-1:0] size_in, size_best;
	logic [MSG_W-1:0]   order_id;
	logic               pos_lt, id_ok, match, done, out_free;
	logic [LB:0]        nexp_cur, new_nexp;
	logic [LB-1:0]      len_cur;
	logic [TOTAL_W-1:0] peak_new;
	logic               scan_end;
	logic [MSG_W-1:0]   rd_msg;
	logic [LB-1:0]      rd_first, rd_last;
	logic               better;

	assign cur_first = LB'(cur_q.first);
	assign cur_last  = LB'(cur_q.last);
	assign size_in   = TOTAL_W'(cur_last) - TOTAL_W'(cur_first) + TOTAL_W'(1);
	assign size_best = TOTAL_W'(best_last_q) - TOTAL_W'(best_first_q) + TOTAL_W'(1);
	assign order_id  = MSG_W'(order >> {pos_q[1:0], 1'b0});
	assign pos_lt    = pos_q < act_count;
	assign id_ok     = {1'b0, order_id} < CNT_W'(MAX_MESSAGES);
	assign nexp_cur  = nexp_q[MIW'(cur_id_q)];
	assign match     = best_v_q && ({1'b0, best_first_q} == nexp_cur);
	assign new_nexp  = {1'b0, best_last_q} + (LB+1)'(1);
	assign len_cur   = LB'(lengths[cur_id_q]);
	assign done      = new_nexp > {1'b0, len_cur};
	assign peak_new  = (pos_lt && total_q > peak_q) ? total_q : peak_q;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_end  = (scan_cnt_q == (AW+1)'(FRAGMENT_SLOTS));

	assign rd_msg   = rd_data_s1[ENT_W-1 -: MSG_W];
	assign rd_first = rd_data_s1[2*LB-1:LB];
	assign rd_last  = rd_data_s1[LB-1:0];
	assign better   = rd_vld_s1 && (rd_msg == cur_id_q) &&
		(!best_v_q || rd_first < best_first_q ||
		 (rd_first == best_first_q && rd_last < best_last_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (!q_empty) state_d = S_STORE;
			S_STORE:     state_d = (cur_q.kind == K_CLEAR) ? S_FINISH : S_DRAIN_CHK;
			S_DRAIN_CHK: state_d = (pos_lt && id_ok) ? S_SCAN : S_FINISH;
			S_SCAN:      if (scan_end) state_d = S_DECIDE;
			S_DECIDE:    state_d = match ? S_DRAIN_CHK : S_FINISH;
			S_FINISH:    if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// control decodes
	logic mem_we, release_en, out_load, scan_rd, scan_start;
	always_comb begin
		pop        = (state_q == S_IDLE) && !q_empty;
		mem_we     = (state_q == S_STORE) && (cur_q.kind == K_FRAG) && free_found;
		release_en = (state_q == S_DECIDE) && match;
		out_load   = (state_q == S_FINISH) && out_free;
		scan_rd    = (state_q == S_SCAN) && !scan_end;
		scan_start = (state_q == S_DRAIN_CHK) && pos_lt && id_ok;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[free_idx] <= {cur_q.msg, cur_first, cur_last};
		rd_data_s1 <= mem[scan_cnt_q[AW-1:0]];
		rd_idx_s1  <= scan_cnt_q[AW-1:0];
		if (pop)
			cur_q <= head;
		if (scan_start)
			cur_id_q <= order_id;
		if (better) begin
			best_idx_q   <= rd_idx_s1;
			best_first_q <= rd_first;
			best_last_q  <= rd_last;
		end
		if (out_load) begin
			out_total_q <= total_q;
			out_peak_q  <= peak_new;
			out_pos_q   <= pos_q;
			out_drop_q  <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			for (int m = 0; m < MAX_MESSAGES; m++)
				nexp_q[m] <= (LB+1)'(1);
			pos_q       <= '0;
			total_q     <= '0;
			peak_q      <= '0;
			dropped_q   <= 1'b0;
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			best_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_rd && valid_q[scan_cnt_q[AW-1:0]];
			if (scan_rd)
				scan_cnt_q <= scan_cnt_q + 1'b1;
			if (scan_start) begin
				scan_cnt_q <= '0;
				best_v_q   <= 1'b0;
			end else if (better) begin
				best_v_q <= 1'b1;
			end
			if (state_q == S_STORE) begin
				unique case (cur_q.kind)
					K_CLEAR: begin
						valid_q   <= '0;
						for (int m = 0; m < MAX_MESSAGES; m++)
							nexp_q[m] <= (LB+1)'(1);
						pos_q     <= '0;
						total_q   <= '0;
						peak_q    <= '0;
						dropped_q <= 1'b0;
					end
					K_FRAG: begin
						dropped_q <= !free_found;
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							total_q           <= total_q + size_in;
						end
					end
					default: dropped_q <= 1'b1;
				endcase
			end
			if (release_en) begin
				valid_q[best_idx_q]     <= 1'b0;
				total_q                 <= total_q - size_best;
				nexp_q[MIW'(cur_id_q)] <= new_nexp;
				if (done)
					pos_q <= pos_q + 1'b1;
			end
			if (out_load) begin
				peak_q      <= peak_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign buffered_bytes = out_total_q;
	assign peak_bytes     = out_peak_q;
	assign messages_done  = out_pos_q;
	assign dropped        = out_drop_q;

	a_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_pos_q <= CNT_W'(MAX_MESSAGES))
		else $error("messages_done beyond message count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_cnt_q <= (AW+1)'(FRAGMENT_SLOTS))
		else $error("scan counter past store depth");

	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		release_en |=> !valid_q[$past(best_idx_q)])
		else $error("released fragment still valid");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cur_q.kind == K_CLEAR) |=>
			(out_valid_q && out_total_q == '0 && out_peak_q == '0 && out_pos_q == '0))
		else $error("clear item did not report zeros");

endmodule

### hdl/fragment_reassembly_occupancy.sv
// Top level: APB register file, front classifier, item queue and reassembly back end.
//
// Reassembly buffer for up to four messages delivered in a programmed order. Items
// are taken by the front into a two-entry queue while the back end works, so the
// input stays open as long as the queue has room. The back end handles one item at
// a time. Each drain attempt is a check, a sweep of the fragment store and a
// decide; an item may drain several fragments before its result is loaded, and the
// result is held until it is taken. The sweep reads the fragment store through its
// single read port. Slot valid bits are flops, so no clearing pass follows reset.
// The user must write registers only while the block is idle; the block itself
// does not enforce this.
module fragment_reassembly_occupancy import fra_pkg::*; #(
	parameter int MAX_MESSAGES   = DEF_MAX_MESSAGES,
	parameter int FRAGMENT_SLOTS = DEF_FRAGMENT_SLOTS,
	parameter int LENGTH_BITS    = DEF_LENGTH_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [MSG_W-1:0]    message_number,
	input  logic [POS_IN_W-1:0] first_byte,
	input  logic [POS_IN_W-1:0] last_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TOTAL_W-1:0]  buffered_bytes,
	output logic [TOTAL_W-1:0]  peak_bytes,
	output logic [CNT_W-1:0]    messages_done,
	output logic                dropped
);

	logic [CNT_W-1:0]   msg_count_q;
	logic [ORDER_W-1:0] order_q;
	len_arr_t           len_q;
	logic [2:0]         reg_idx;
	logic               wr_en;
	logic [CNT_W-1:0]   act_count;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign act_count = (msg_count_q > CNT_W'(MAX_MESSAGES)) ? CNT_W'(MAX_MESSAGES)
		: msg_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_count_q <= RST_MSG_COUNT;
			order_q     <= RST_ORDER;
			for (int i = 0; i < NUM_LEN_REGS; i++)
				len_q[i] <= RST_LEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MSG_COUNT: msg_count_q <= pwdata[CNT_W-1:0];
				REG_ORDER:     order_q     <= pwdata[ORDER_W-1:0];
				REG_LEN0:      len_q[0]    <= pwdata[POS_IN_W-1:0];
				REG_LEN1:      len_q[1]    <= pwdata[POS_IN_W-1:0];
				REG_LEN2:      len_q[2]    <= pwdata[POS_IN_W-1:0];
				REG_LEN3:      len_q[3]    <= pwdata[POS_IN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MSG_COUNT: prdata = 32'(msg_count_q);
			REG_ORDER:     prdata = 32'(order_q);
			REG_LEN0:      prdata = 32'(len_q[0]);
			REG_LEN1:      prdata = 32'(len_q[1]);
			REG_LEN2:      prdata = 32'(len_q[2]);
			REG_LEN3:      prdata = 32'(len_q[3]);
			default:       prdata = '0;
		endcase
	end

	logic  push, pop, q_empty, q_full;
	item_t push_item, head;

	fra_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.message_number (message_number),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.act_count      (act_count),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	fra_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	fra_back #(
		.MAX_MESSAGES   (MAX_MESSAGES),
		.FRAGMENT_SLOTS (FRAGMENT_SLOTS),
		.LENGTH_BITS    (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.pop            (pop),
		.act_count      (act_count),
		.order          (order_q),
		.lengths        (len_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.buffered_bytes (buffered_bytes),
		.peak_bytes     (peak_bytes),
		.messages_done  (messages_done),
		.dropped        (dropped)
	);

endmodule
